### hdl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// shared types and constants for the mqtt publish packet framer
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int          BYTE_W      = 8;
  localparam int          TLEN_W      = 16;
  localparam int          MLEN_W      = 28;
  localparam int          QOS_W       = 2;
  localparam int          IDENT_W     = 16;
  localparam int          BURST_DEPTH = 9;
  localparam int          CNT_W       = $clog2(BURST_DEPTH + 1);
  localparam int          POS_W       = $clog2(BURST_DEPTH);
  localparam int          VARLEN_BASE = 128;
  localparam int          GRP_W       = $clog2(VARLEN_BASE);
  localparam int          VARLEN_MAXB = 4;
  localparam int          FIXED_W     = TLEN_W + 2;

  localparam logic [BYTE_W-1:0]  PUBLISH_TYPE = 8'h30;
  localparam logic [MLEN_W-1:0]  REMLEN_MAX   = 28'hFFFFFFF;
  localparam logic [QOS_W-1:0]   QOS_TWO      = 2'd2;
  localparam logic [QOS_W-1:0]   QOS_THREE    = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_TOPIC   = 3'b010,
    PH_MESSAGE = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [IDENT_W-1:0]  packet_ident;
    logic [TLEN_W-1:0]   topic_left;
    logic [MLEN_W-1:0]   message_left;
    logic                ident_pending;
  } state_t;

  typedef struct packed {
    logic                  start_req;
    logic [TLEN_W-1:0]     topic_len;
    logic [MLEN_W-1:0]     msg_len;
    logic [QOS_W-1:0]      qos;
    logic [BYTE_W-1:0]     data_byte;
  } item_t;

  typedef struct packed {
    byte_t [BURST_DEPTH-1:0] bytes;
    logic  [CNT_W-1:0]       cnt;
    logic                    last;
  } burst_t;

endpackage

### hdl/mpf_core.sv
// ----------------------------------------------------------------------------
// mpf_core
// single-pass encoder: one request and the framer state in, byte burst and
// next state out
// ----------------------------------------------------------------------------
module mpf_core
  import mpf_pkg::*;
(
  input  item_t  item,
  input  state_t st,
  output burst_t res,
  output state_t st_nxt
);

  logic [QOS_W-1:0]    qe;
  logic [FIXED_W-1:0]  fixed;
  logic [MLEN_W:0]     sum;
  logic [MLEN_W-1:0]   mlen_eff;
  logic [MLEN_W-1:0]   total;
  logic [2:0]          nv;
  logic [POS_W-1:0]    pos;
  logic                done;
  logic                pend;
  logic [MLEN_W-1:0]   mleft;
  logic [TLEN_W-1:0]   tl_dec;
  logic [MLEN_W-1:0]   ml_dec;

  always_comb begin
    qe       = (item.qos == QOS_THREE) ? QOS_TWO : item.qos;
    fixed    = FIXED_W'(item.topic_len) + FIXED_W'(2) + ((qe != '0) ? FIXED_W'(2) : '0);
    sum      = (MLEN_W+1)'(fixed) + {1'b0, item.msg_len};
    if (sum > {1'b0, REMLEN_MAX}) begin
      mlen_eff = REMLEN_MAX - MLEN_W'(fixed);
      total    = REMLEN_MAX;
    end else begin
      mlen_eff = item.msg_len;
      total    = sum[MLEN_W-1:0];
    end
    if (total >= MLEN_W'(VARLEN_BASE ** 3)) begin
      nv = 3'd4;
    end else if (total >= MLEN_W'(VARLEN_BASE ** 2)) begin
      nv = 3'd3;
    end else if (total >= MLEN_W'(VARLEN_BASE)) begin
      nv = 3'd2;
    end else begin
      nv = 3'd1;
    end
    tl_dec = (st.topic_left != '0) ? st.topic_left - 1'b1 : '0;
    ml_dec = (st.message_left != '0) ? st.message_left - 1'b1 : '0;
  end

  always_comb begin
    res    = '0;
    st_nxt = st;
    pos    = '0;
    done   = 1'b0;
    pend   = st.ident_pending;
    mleft  = st.message_left;
    if (item.start_req) begin
      res.bytes[0] = PUBLISH_TYPE | BYTE_W'({qe, 1'b0});
      for (int k = 0; k < VARLEN_MAXB; k++) begin
        if (3'(k) < nv) begin
          res.bytes[1 + k] = {(3'(k + 1) < nv), total[k*GRP_W +: GRP_W]};
        end
      end
      pos = POS_W'(nv) + POS_W'(1);
      res.bytes[pos] = item.topic_len[15:8];
      res.bytes[pos + POS_W'(1)] = item.topic_len[7:0];
      pos = pos + POS_W'(2);
      st_nxt.phase         = PH_TOPIC;
      st_nxt.topic_left    = item.topic_len;
      st_nxt.message_left  = mlen_eff;
      st_nxt.ident_pending = (qe != '0);
      pend  = (qe != '0);
      mleft = mlen_eff;
      done  = (item.topic_len == '0);
    end else begin
      case (st.phase)
        PH_TOPIC: begin
          res.bytes[0] = item.data_byte;
          pos = POS_W'(1);
          st_nxt.topic_left = tl_dec;
          done = (tl_dec == '0);
        end
        PH_MESSAGE: begin
          res.bytes[0] = item.data_byte;
          pos = POS_W'(1);
          st_nxt.message_left = ml_dec;
          if (ml_dec == '0) begin
            res.last     = 1'b1;
            st_nxt.phase = PH_IDLE;
          end
        end
        default: begin
          pos = '0;
        end
      endcase
    end
    if (done) begin
      if (pend) begin
        res.bytes[pos] = st.packet_ident[15:8];
        res.bytes[pos + POS_W'(1)] = st.packet_ident[7:0];
        pos = pos + POS_W'(2);
        st_nxt.packet_ident  = st.packet_ident + 1'b1;
        st_nxt.ident_pending = 1'b0;
      end
      if (mleft == '0) begin
        res.last     = 1'b1;
        st_nxt.phase = PH_IDLE;
      end else begin
        st_nxt.phase = PH_MESSAGE;
      end
    end
    res.cnt = CNT_W'(pos);
  end

endmodule

### hdl/mpf_burst.sv
// ----------------------------------------------------------------------------
// mpf_burst
// result register: holds one burst of bytes and, while the output is not stalled, shifts it out one a cycle
// ----------------------------------------------------------------------------
module mpf_burst
  import mpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  burst_t     burst,
  output logic       free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_byte
);

  byte_t [BURST_DEPTH-1:0] data_r;
  logic  [CNT_W-1:0]       rem_r;
  logic                    last_r;
  logic                    take;

  assign out_valid     = (rem_r != '0);
  assign take          = out_valid && !out_stall;
  assign free          = (rem_r == '0) || ((rem_r == CNT_W'(1)) && take);
  assign out_byte      = data_r[0];
  assign out_last_byte = last_r && (rem_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (load) begin
      rem_r <= burst.cnt;
    end else if (take) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= burst.bytes;
      last_r <= burst.last;
    end else if (take) begin
      for (int k = 0; k < BURST_DEPTH - 1; k++) begin
        data_r[k] <= data_r[k + 1];
      end
    end
  end

endmodule

### hdl/mqtt_publish_packet_framer.sv
// a request's first byte passes the input register, then the output shift register
// throughput: a one-byte data request is taken every cycle while the output is not stalled
// a start request emits 4 to 9 bytes and holds the input side until the one-byte-wide
// output shift register is sending its last byte
// reset: synchronous, active low; clears the packet state, identifier and both stages
// ----------------------------------------------------------------------------
// mqtt_publish_packet_framer
// frames mqtt publish packets from start and data requests into a byte stream
// ----------------------------------------------------------------------------
module mqtt_publish_packet_framer
  import mpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic [15:0] in_topic_len,
  input  logic [27:0] in_msg_len,
  input  logic [1:0]  in_qos,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte
);

  item_t  item_r;
  logic   in_v_r;
  state_t st_r;
  state_t st_nxt;
  burst_t burst;
  logic   free;
  logic   load;
  logic   accept;

  assign load     = in_v_r && free;
  assign in_stall = in_v_r && !free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (load) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{start_req: in_start_req, topic_len: in_topic_len, msg_len: in_msg_len,
                 qos: in_qos, data_byte: in_data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, packet_ident: '0, topic_left: '0, message_left: '0,
               ident_pending: 1'b0};
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  mpf_core u_core (
    .item   (item_r),
    .st     (st_r),
    .res    (burst),
    .st_nxt (st_nxt)
  );

  mpf_burst u_burst (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .burst         (burst),
    .free          (free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

### hdl/mpf_checker.sv
// ----------------------------------------------------------------------------
// mpf_checker
// port-level checks for the mqtt publish packet framer
// ----------------------------------------------------------------------------
module mpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_byte
);

  // held output request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_byte))
    else $error("output request changed while stalled");

  // input only waits behind pending output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no output pending");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stall with nothing buffered ahead is never seen right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind mqtt_publish_packet_framer mpf_checker u_mpf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_last_byte (out_last_byte)
);
